// ----- rtl/assert_macros.svh -----
// assertion macros used by the top level rtl file
// no dependencies; the including scope provides clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SGCU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SGCU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/sgcu_pkg.sv -----
// shared types, constants and helper functions of the seir grid cell update block
// no dependencies
`default_nettype none

package sgcu_pkg;

    localparam int DEF_GRID_ROWS = 8;
    localparam int DEF_GRID_COLS = 8;

    localparam int VAL_W  = 24;
    localparam int RATE_W = 17;
    localparam int SUM_W  = 27;
    localparam int PROD_W = 65;

    localparam logic [VAL_W-1:0] VAL_MAX     = 24'd16777215;
    localparam logic [VAL_W-1:0] FULL_POP    = 24'd6553600;
    localparam logic [VAL_W-1:0] SEED_AMOUNT = 24'd327680;

    localparam logic [RATE_W-1:0] RST_INFECTION  = 17'd32768;
    localparam logic [RATE_W-1:0] RST_INCUBATION = 17'd32768;
    localparam logic [RATE_W-1:0] RST_RECOVERY   = 17'd4369;
    localparam logic [RATE_W-1:0] RST_TIME_STEP  = 17'd65536;

    // request codes
    localparam logic REQ_SEED   = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_INFECTION  = 2'd0;
    localparam logic [1:0] CFG_INCUBATION = 2'd1;
    localparam logic [1:0] CFG_RECOVERY   = 2'd2;
    localparam logic [1:0] CFG_TIME_STEP  = 2'd3;

    // cell classes
    localparam logic [1:0] CLS_S = 2'd0;
    localparam logic [1:0] CLS_E = 2'd1;
    localparam logic [1:0] CLS_I = 2'd2;
    localparam logic [1:0] CLS_R = 2'd3;

    // number of neighbour slots and last multiply step
    localparam logic [3:0] NBR_LAST = 4'd8;
    localparam logic [3:0] MUL_LAST = 4'd8;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CENTER,
        ST_NBR,
        ST_MUL,
        ST_WB
    } state_t;

    typedef struct packed {
        logic load_req;
        logic clear_step;
        logic latch_center;
        logic nbr_step;
        logic mul_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic in_grid;
        logic is_seed;
        logic nbr_done;
        logic mul_done;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic signed [1:0] dr;
        logic signed [1:0] dc;
    } nbr_off_t;

    // moore neighbour offsets, centre skipped
    function automatic nbr_off_t nbr_offset(input logic [2:0] k);
        nbr_off_t o;
        case (k)
            3'd0:    o = '{dr: -2'sd1, dc: -2'sd1};
            3'd1:    o = '{dr: -2'sd1, dc:  2'sd0};
            3'd2:    o = '{dr: -2'sd1, dc:  2'sd1};
            3'd3:    o = '{dr:  2'sd0, dc: -2'sd1};
            3'd4:    o = '{dr:  2'sd0, dc:  2'sd1};
            3'd5:    o = '{dr:  2'sd1, dc: -2'sd1};
            3'd6:    o = '{dr:  2'sd1, dc:  2'sd0};
            default: o = '{dr:  2'sd1, dc:  2'sd1};
        endcase
        return o;
    endfunction

    // floor(2^32 / count) for the possible neighbour counts
    function automatic logic [31:0] recip32(input logic [3:0] cnt);
        logic [31:0] m;
        case (cnt)
            4'd3:    m = 32'd1431655765;
            4'd5:    m = 32'd858993459;
            default: m = 32'd536870912;
        endcase
        return m;
    endfunction

    // clamp at zero, saturate at the q8.16 maximum
    function automatic logic [VAL_W-1:0] sat_val(input logic signed [36:0] v);
        logic [VAL_W-1:0] r;
        if (v < 37'sd0)
            r = '0;
        else if (v > 37'sd16777215)
            r = VAL_MAX;
        else
            r = v[VAL_W-1:0];
        return r;
    endfunction

    // last nonzero of e, i, r wins
    function automatic logic [1:0] cell_class_of(input logic [VAL_W-1:0] e,
                                                 input logic [VAL_W-1:0] i,
                                                 input logic [VAL_W-1:0] r);
        logic [1:0] c;
        c = CLS_S;
        if (e != '0)
            c = CLS_E;
        if (i != '0)
            c = CLS_I;
        if (r != '0)
            c = CLS_R;
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sgcu_req_if.sv -----
// request channel interface: request type and cell address
// no dependencies
`default_nettype none

interface sgcu_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [2:0] row;
    logic [2:0] col;

    modport source (output valid, output req_type, output row, output col, input ready);
    modport sink   (input valid, input req_type, input row, input col, output ready);
endinterface

`default_nettype wire

// ----- rtl/sgcu_res_if.sv -----
// result channel interface: cell contents, class and accept flag
// no dependencies
`default_nettype none

interface sgcu_res_if;
    logic        valid;
    logic        ready;
    logic [23:0] s_value;
    logic [23:0] e_value;
    logic [23:0] i_value;
    logic [23:0] r_value;
    logic [1:0]  cell_class;
    logic        accepted;

    modport source (output valid, output s_value, output e_value, output i_value,
                    output r_value, output cell_class, output accepted, input ready);
    modport sink   (input valid, input s_value, input e_value, input i_value,
                    input r_value, input cell_class, input accepted, output ready);
endinterface

`default_nettype wire

// ----- rtl/sgcu_cfg_if.sv -----
// configuration write channel interface: register index and data
// no dependencies
`default_nettype none

interface sgcu_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/sgcu_ctrl.sv -----
// controller state machine of the cell update block
// depends on sgcu_pkg
`default_nettype none

module sgcu_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire sgcu_pkg::dp_stat_t stat,
    output sgcu_pkg::dp_cmd_t       cmd
);
    import sgcu_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (stat.clear_done)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (req_valid)
                    state_next = ST_READ;
            ST_READ:
                state_next = stat.in_grid ? ST_CENTER : ST_WB;
            ST_CENTER:
                state_next = stat.is_seed ? ST_WB : ST_NBR;
            ST_NBR:
                if (stat.nbr_done)
                    state_next = ST_MUL;
            ST_MUL:
                if (stat.mul_done)
                    state_next = ST_WB;
            ST_WB:
                if (stat.out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_CLEAR;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:  cmd.clear_step = 1'b1;
            ST_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.load_req = req_valid;
            end
            ST_READ:   cmd = '0;
            ST_CENTER: cmd.latch_center = 1'b1;
            ST_NBR:    cmd.nbr_step = 1'b1;
            ST_MUL:    cmd.mul_step = 1'b1;
            ST_WB:     cmd.finish = stat.out_free;
            default:   cmd = '0;
        endcase
    end
endmodule

`default_nettype wire

// ----- rtl/sgcu_dp.sv -----
// datapath: grid memory, neighbour averaging, shared multiplier, result register
// depends on sgcu_pkg and the result and configuration channel interfaces
`default_nettype none

module sgcu_dp #(
    parameter int GRID_ROWS = sgcu_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS = sgcu_pkg::DEF_GRID_COLS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_type,
    input  wire logic [2:0]        row,
    input  wire logic [2:0]        col,
    input  wire sgcu_pkg::dp_cmd_t cmd,
    output sgcu_pkg::dp_stat_t     stat,
    sgcu_res_if.source             res,
    sgcu_cfg_if.sink               cfg
);
    import sgcu_pkg::*;

    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int ENT_W = 4 * VAL_W;

    // grid memory, one entry {s, e, i, r} per cell
    logic [ENT_W-1:0] mem [CELLS];
    logic [ENT_W-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [ENT_W-1:0] wr_data;

    logic [AW-1:0]     clear_addr_reg;
    logic              req_type_reg;
    logic [2:0]        row_reg;
    logic [2:0]        col_reg;
    logic [VAL_W-1:0]  s_reg, e_reg, i_reg, r_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [3:0]        cnt_reg;
    logic              pend_reg;
    logic [3:0]        k_reg;
    logic [3:0]        mul_idx_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [VAL_W-1:0]  avg_reg;
    logic [33:0]       inf_reg;
    logic [25:0]       inc_reg;
    logic [25:0]       rec_reg;
    logic [RATE_W-1:0] beta_reg, sigma_reg, gamma_reg, dt_reg;
    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_s_reg, out_e_reg, out_i_reg, out_r_reg;
    logic [1:0]        out_cls_reg;
    logic              out_acc_reg;

    logic              in_grid;
    logic [AW-1:0]     center_addr;
    nbr_off_t          off;
    logic signed [7:0] nr, nc;
    logic              nbr_ok;
    logic [AW-1:0]     nbr_addr;
    logic [32:0]       mul_a;
    logic [31:0]       mul_b;
    logic [26:0]       quot;
    logic [27:0]       rem;
    logic              seed_ok;
    logic [VAL_W-1:0]  s_new, e_new, i_new, r_new;
    logic              acc_new;
    logic              do_write;

    // cell address and grid checks
    always_comb
    begin
        in_grid     = (int'(row_reg) < GRID_ROWS) && (int'(col_reg) < GRID_COLS);
        center_addr = AW'(int'(row_reg) * GRID_COLS + int'(col_reg));
        off         = nbr_offset(k_reg[2:0]);
        nr          = $signed({5'b0, row_reg}) + 8'(off.dr);
        nc          = $signed({5'b0, col_reg}) + 8'(off.dc);
        nbr_ok      = (nr >= 8'sd0) && (int'(nr) < GRID_ROWS) &&
                      (nc >= 8'sd0) && (int'(nc) < GRID_COLS);
        nbr_addr    = AW'(int'(nr) * GRID_COLS + int'(nc));
        rd_addr     = cmd.nbr_step ? nbr_addr : center_addr;
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // configuration registers
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg  <= RST_INFECTION;
            sigma_reg <= RST_INCUBATION;
            gamma_reg <= RST_RECOVERY;
            dt_reg    <= RST_TIME_STEP;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_INFECTION:  beta_reg  <= cfg.data;
                CFG_INCUBATION: sigma_reg <= cfg.data;
                CFG_RECOVERY:   gamma_reg <= cfg.data;
                CFG_TIME_STEP:  dt_reg    <= cfg.data;
                default:        dt_reg    <= dt_reg;
            endcase
        end
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clear_addr_reg <= '0;
        else if (cmd.clear_step)
            clear_addr_reg <= clear_addr_reg + AW'(1);
    end

    // request capture and centre cell
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg <= req_type;
            row_reg      <= row;
            col_reg      <= col;
        end
        if (cmd.latch_center)
        begin
            s_reg <= rd_data_reg[4*VAL_W-1:3*VAL_W];
            e_reg <= rd_data_reg[3*VAL_W-1:2*VAL_W];
            i_reg <= rd_data_reg[2*VAL_W-1:VAL_W];
            r_reg <= rd_data_reg[VAL_W-1:0];
        end
    end

    // neighbour sweep, one read issued per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= '0;
            pend_reg <= 1'b0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.latch_center)
        begin
            k_reg    <= '0;
            pend_reg <= 1'b0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.nbr_step)
        begin
            if (pend_reg)
            begin
                sum_reg <= sum_reg + SUM_W'(rd_data_reg[2*VAL_W-1:VAL_W]);
                cnt_reg <= cnt_reg + 4'd1;
            end
            pend_reg <= (k_reg != NBR_LAST) && nbr_ok;
            k_reg    <= k_reg + 4'd1;
        end
    end

    // operand select of the shared multiplier
    always_comb
    begin
        case (mul_idx_reg)
            4'd0:    begin mul_a = 33'(sum_reg);        mul_b = recip32(cnt_reg); end
            4'd1:    begin mul_a = 33'(s_reg);          mul_b = 32'(beta_reg);    end
            4'd2:    begin mul_a = prod_reg[48:16];     mul_b = 32'(avg_reg);     end
            4'd3:    begin mul_a = prod_reg[48:16];     mul_b = 32'(dt_reg);      end
            4'd4:    begin mul_a = 33'(e_reg);          mul_b = 32'(sigma_reg);   end
            4'd5:    begin mul_a = prod_reg[48:16];     mul_b = 32'(dt_reg);      end
            4'd6:    begin mul_a = 33'(i_reg);          mul_b = 32'(gamma_reg);   end
            4'd7:    begin mul_a = prod_reg[48:16];     mul_b = 32'(dt_reg);      end
            default: begin mul_a = '0;                  mul_b = '0;               end
        endcase
        quot = prod_reg[58:32];
        rem  = {1'b0, sum_reg} - (28'(quot) * 28'(cnt_reg));
    end

    // multiply sequence: average, infection, incubation, recovery
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_idx_reg <= '0;
        else if (cmd.latch_center)
            mul_idx_reg <= '0;
        else if (cmd.mul_step && (mul_idx_reg != MUL_LAST))
            mul_idx_reg <= mul_idx_reg + 4'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_step)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
            case (mul_idx_reg)
                4'd1:    avg_reg <= (rem >= 28'(cnt_reg)) ? VAL_W'(quot + 27'd1)
                                                          : VAL_W'(quot);
                4'd4:    inf_reg <= prod_reg[49:16];
                4'd6:    inc_reg <= prod_reg[41:16];
                4'd8:    rec_reg <= prod_reg[41:16];
                default: avg_reg <= avg_reg;
            endcase
        end
    end

    // new cell contents
    always_comb
    begin
        seed_ok = (i_reg == '0) && (s_reg >= SEED_AMOUNT);
        if (!in_grid)
        begin
            {s_new, e_new, i_new, r_new} = '0;
            acc_new  = 1'b0;
            do_write = 1'b0;
        end
        else if (req_type_reg == REQ_SEED)
        begin
            s_new    = seed_ok ? s_reg - SEED_AMOUNT : s_reg;
            e_new    = e_reg;
            i_new    = seed_ok ? SEED_AMOUNT : i_reg;
            r_new    = r_reg;
            acc_new  = seed_ok;
            do_write = seed_ok;
        end
        else
        begin
            s_new    = sat_val($signed({13'b0, s_reg}) - $signed({3'b0, inf_reg}));
            e_new    = sat_val($signed({13'b0, e_reg}) + $signed({3'b0, inf_reg})
                               - $signed({11'b0, inc_reg}));
            i_new    = sat_val($signed({13'b0, i_reg}) + $signed({11'b0, inc_reg})
                               - $signed({11'b0, rec_reg}));
            r_new    = sat_val($signed({13'b0, r_reg}) + $signed({11'b0, rec_reg}));
            acc_new  = 1'b1;
            do_write = 1'b1;
        end
    end

    // write port select
    always_comb
    begin
        if (cmd.clear_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clear_addr_reg;
            wr_data = {FULL_POP, {(3*VAL_W){1'b0}}};
        end
        else
        begin
            wr_en   = cmd.finish && do_write;
            wr_addr = center_addr;
            wr_data = {s_new, e_new, i_new, r_new};
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_s_reg   <= s_new;
            out_e_reg   <= e_new;
            out_i_reg   <= i_new;
            out_r_reg   <= r_new;
            out_cls_reg <= in_grid ? cell_class_of(e_new, i_new, r_new) : CLS_S;
            out_acc_reg <= acc_new;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.s_value    = out_s_reg;
    assign res.e_value    = out_e_reg;
    assign res.i_value    = out_i_reg;
    assign res.r_value    = out_r_reg;
    assign res.cell_class = out_cls_reg;
    assign res.accepted   = out_acc_reg;

    // status to the controller
    always_comb
    begin
        stat.clear_done = (clear_addr_reg == AW'(CELLS - 1));
        stat.in_grid    = in_grid;
        stat.is_seed    = (req_type_reg == REQ_SEED);
        stat.nbr_done   = (k_reg == NBR_LAST);
        stat.mul_done   = (mul_idx_reg == MUL_LAST);
        stat.out_free   = !out_valid_reg || res.ready;
    end
endmodule

`default_nettype wire

// ----- rtl/seir_grid_cell_update.sv -----
// top level of the seir grid cell update block
// depends on sgcu_pkg, the channel interfaces, sgcu_ctrl, sgcu_dp and assert_macros.svh
//
//   channel  role  payload
//   req      sink  req_type, row, col
//   res      src   s_value, e_value, i_value, r_value, cell_class, accepted
//   cfg      sink  index, data (always ready)
//
// a seed item is read, latched and written back if accepted; an update also reads the
// neighbours through the one memory read port and runs the shared multiplier sequence
// after reset a clearing pass over all GRID_ROWS*GRID_COLS cells holds req.ready low
// one item at a time; the next item is taken while the last result waits in res
// an item finishes only once the result register is free
`default_nettype none
`include "assert_macros.svh"

module seir_grid_cell_update #(
    parameter int GRID_ROWS = sgcu_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS = sgcu_pkg::DEF_GRID_COLS
) (
    input wire logic clk,
    input wire logic rst_n,
    sgcu_req_if.sink   req,
    sgcu_res_if.source res,
    sgcu_cfg_if.sink   cfg
);
    import sgcu_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // controller
    sgcu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    sgcu_dp #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_type (req.req_type),
        .row      (req.row),
        .col      (req.col),
        .cmd      (cmd),
        .stat     (stat),
        .res      (res),
        .cfg      (cfg)
    );

    // checks
    `SGCU_ASSERT_NEXT(a_one_item, req.valid && req.ready, !req.ready)
    `SGCU_ASSERT_SAME(a_finish_free, cmd.finish, stat.out_free)
    `SGCU_ASSERT_SAME(a_load_accept, cmd.load_req, req.valid && req.ready)
endmodule

`default_nettype wire
